[rtl/core/bdq_pkg.sv]
// bdq_pkg: request/response types and codes for the bounded deque with search
// no dependencies
package bdq_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned FLD_W = 5;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_FIND_FIRST = 3'd4;
    localparam logic [2:0] REQ_FIND_LAST  = 3'd5;
    localparam logic [2:0] REQ_COUNT      = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [VAL_W-1:0]  value_in;
    } t_req_in;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value_out;
        logic [FLD_W-1:0]         position;
        logic [FLD_W-1:0]         element_count;
        logic [1:0]               status;
    } t_resp_out;

endpackage

[rtl/core/bdq_ram.sv]
// bdq_ram: element store, one write port and one read port with registered read data
// uses bdq_pkg for the word width
module bdq_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [bdq_pkg::VAL_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [bdq_pkg::VAL_W-1:0] o_rd_data
);
    import bdq_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/bdq_ctrl.sv]
// bdq_ctrl: request sequencer, ring pointers, search walk and output register
// uses bdq_pkg; drives the ports of bdq_ram
module bdq_ctrl #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned CW    = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bdq_pkg::t_req_in          i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bdq_pkg::t_resp_out        o_out_resp,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [bdq_pkg::VAL_W-1:0] o_wr_data,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr,
    input  logic [bdq_pkg::VAL_W-1:0] i_rd_data
);
    import bdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POPRD,
        S_SCAN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [2:0]           r_req;
    logic [VAL_W-1:0]     r_key;
    logic [AW-1:0]        r_front;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_issue;
    logic                 r_pend;
    logic [CW-1:0]        r_pend_k;
    logic [CW-1:0]        r_pos;
    logic [VAL_W-1:0]     r_val;
    logic [1:0]           r_st;
    logic                 r_out_valid;
    t_resp_out            r_out_resp;

    logic                 full;
    logic                 empty;
    logic                 is_push;
    logic                 is_pop;
    logic [AW-1:0]        front_dec;
    logic [AW-1:0]        front_inc;
    logic [AW-1:0]        slot_back;
    logic [AW-1:0]        slot_last;
    logic [AW-1:0]        slot_scan;
    logic [CW-1:0]        count_m1;
    logic                 hit;
    logic                 out_free;
    logic [CW+FLD_W-1:0]  pos_ext;
    logic [CW+FLD_W-1:0]  cnt_ext;

    // ring index of front + off, both below DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign is_push   = (r_req == REQ_PUSH_FRONT) || (r_req == REQ_PUSH_BACK);
    assign is_pop    = (r_req == REQ_POP_FRONT) || (r_req == REQ_POP_BACK);
    assign count_m1  = r_count - CW'(1);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = ring_add(r_front, AW'(1));
    assign slot_back = ring_add(r_front, r_count[AW-1:0]);
    assign slot_last = ring_add(r_front, count_m1[AW-1:0]);
    assign slot_scan = ring_add(r_front, r_issue[AW-1:0]);
    assign hit       = r_pend && (i_rd_data == r_key);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pos_ext   = {{FLD_W{1'b0}}, r_pos};
    assign cnt_ext   = {{FLD_W{1'b0}}, r_count};

    // memory port drive
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = slot_back;
        o_wr_data = r_key;
        o_rd_en   = 1'b0;
        o_rd_addr = slot_scan;
        if (r_state == S_EXEC) begin
            if (is_push && !full) begin
                o_wr_en = 1'b1;
                if (r_req == REQ_PUSH_FRONT) begin
                    o_wr_addr = front_dec;
                end
            end
            if (is_pop && !empty) begin
                o_rd_en   = 1'b1;
                o_rd_addr = (r_req == REQ_POP_FRONT) ? r_front : slot_last;
            end
        end else if (r_state == S_SCAN) begin
            o_rd_en = (r_issue != r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a response loaded in S_DONE replaces the one leaving
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_req.req_type;
                        r_key   <= i_in_req.value_in;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_val   <= '0;
                    r_pos   <= '0;
                    r_issue <= '0;
                    r_pend  <= 1'b0;
                    unique case (r_req)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            r_state <= S_DONE;
                            if (full) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_st    <= ST_OK;
                                r_count <= r_count + CW'(1);
                                if (r_req == REQ_PUSH_FRONT) begin
                                    r_front <= front_dec;
                                end
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (empty) begin
                                r_st    <= ST_EMPTY;
                                r_state <= S_DONE;
                            end else begin
                                r_st    <= ST_OK;
                                r_count <= count_m1;
                                if (r_req == REQ_POP_FRONT) begin
                                    r_front <= front_inc;
                                end
                                r_state <= S_POPRD;
                            end
                        end
                        REQ_FIND_FIRST, REQ_FIND_LAST, REQ_COUNT: begin
                            r_st    <= ST_OK;
                            r_state <= empty ? S_DONE : S_SCAN;
                        end
                        default: begin
                            // unused code: no change, zero result
                            r_st    <= ST_OK;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_POPRD: begin
                    r_val   <= i_rd_data;
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    // read of entry k issued here, compared in the cycle after, once its data is registered
                    if (r_issue != r_count) begin
                        r_issue  <= r_issue + CW'(1);
                        r_pend   <= 1'b1;
                        r_pend_k <= r_issue;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_DONE;
                        end
                    end
                    if (hit) begin
                        priority case (r_req)
                            REQ_FIND_FIRST: begin
                                if (r_pos == '0) begin
                                    r_pos <= r_pend_k + CW'(1);
                                end
                            end
                            REQ_FIND_LAST: r_pos <= r_pend_k + CW'(1);
                            default:       r_pos <= r_pos + CW'(1);
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out_resp.value_out       <= r_val;
                        r_out_resp.position        <= pos_ext[FLD_W-1:0];
                        r_out_resp.element_count   <= cnt_ext[FLD_W-1:0];
                        r_out_resp.status          <= r_st;
                        r_state                    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_out_resp;

endmodule

[rtl/core/bounded_deque_with_search.sv]
// bounded_deque_with_search: top level, bounded deque of signed words with key search
// uses bdq_pkg, bdq_ctrl and bdq_ram
// usage:
//   input channel  i_in_valid / o_in_stall / i_in_req carries one request:
//   push front, push back, pop front, pop back, find first, find last or
//   count matches of a key. output channel o_out_valid / i_out_stall /
//   o_out_resp returns exactly one response per request, in order, with the
//   element count after the request and a status (ok, empty pop, full push).
//   the block works on one request at a time; o_in_stall is high from the
//   cycle after a request is taken until its response is loaded into the
//   output register.
//   pushes, failed pops and searches of an empty store pass from the
//   request state straight to the response state; a pop first takes its
//   registered read data, and a search walks the stored entries, reading
//   one entry per cycle from the element store. the sequencer returns to
//   idle as a response loads and takes the next request from there.
//   a request is taken while an earlier response waits in the output register;
//   under a stalling receiver the next response holds in the sequencer.
//   reset (i_rst_n low, synchronous) empties the store and drops any
//   pending response; store contents need no clearing.
module bounded_deque_with_search #(
    parameter int unsigned DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bdq_pkg::t_req_in   i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bdq_pkg::t_resp_out o_out_resp
);
    import bdq_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [VAL_W-1:0] rd_data;

    bdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_resp  (o_out_resp),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    bdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
